>>> hw/rtl/wgm_pkg.sv
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types and constants for the glob matcher: item kinds, the special
// pattern bytes and the classified beat that travels from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package wgm_pkg;

  localparam int PATTERN_LEN_DEF = 63;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_SUBJ   = 2'd2,
    MODE_END    = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] ch;
    logic       is_star;
    logic       is_semi;
    logic       is_quest;
  } op_t;

endpackage

`default_nettype wire

>>> hw/rtl/wgm_front.sv
// ----------------------------------------------------------------------------
// wgm_front
// Input side: accept beats, decode the kind and the special pattern bytes,
// and hold them in a short queue toward the matcher.
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_front
  import wgm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] ch
  input  wire logic [1:0] in_tuser,   // [1:0] mode
  output logic            q_valid,
  input  wire logic       q_ready,
  output op_t             q_op
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  op_t           entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r,  count_nxt;
  op_t           dec;
  logic          push, pop;

  always_comb begin
    dec.mode     = mode_t'(in_tuser);
    dec.ch       = in_tdata;
    dec.is_star  = (in_tdata == CH_STAR);
    dec.is_semi  = (in_tdata == CH_SEMI);
    dec.is_quest = (in_tdata == CH_QUEST);
  end

  assign in_tready = (count_r != CW'(QUEUE_DEPTH));
  assign q_valid   = (count_r != '0);
  assign q_op      = entry_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= dec;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wgm_back.sv
// ----------------------------------------------------------------------------
// wgm_back
// Matcher: holds the pattern and its star/semicolon/question masks, tracks
// the active position set one subject byte per cycle, and registers the
// verdict for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_back
  import wgm_pkg::*;
#(
  parameter int PATTERN_LEN = PATTERN_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  output logic            q_ready,
  input  wire op_t        q_op,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [0] matched, [1] pattern_overflow, [7:2] zero
);

  localparam int NPOS = PATTERN_LEN + 1;
  localparam int LW   = $clog2(PATTERN_LEN + 1);
  localparam int IW   = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;

  logic [7:0]             store_r [PATTERN_LEN];
  logic [LW-1:0]          len_r,     len_nxt;
  logic                   ovf_r,     ovf_nxt;
  logic [PATTERN_LEN-1:0] star_r,    star_nxt;
  logic [PATTERN_LEN-1:0] semi_r,    semi_nxt;
  logic [PATTERN_LEN-1:0] quest_r,   quest_nxt;
  logic [NPOS-1:0]        init_r,    init_nxt;
  logic [NPOS-1:0]        active_r,  active_nxt;
  logic                   started_r, started_nxt;
  logic                   ovalid_r,  ovalid_nxt;
  logic                   matched_r, matched_nxt;
  logic                   oovf_r,    oovf_nxt;

  logic                   take;
  logic                   do_write;
  logic [NPOS-1:0]        cur;
  logic [NPOS-1:0]        adv;
  logic                   accept_now;

  function automatic logic [NPOS-1:0] close_stars(input logic [NPOS-1:0]        a,
                                                  input logic [PATTERN_LEN-1:0] s);
    logic [NPOS-1:0] acc;
    logic [NPOS-1:0] m;
    acc = a;
    m   = {1'b0, s};
    for (int d = 1; d < NPOS; d = d * 2) begin
      acc = acc | ((acc & m) << d);
      m   = m & (m >> d);
    end
    return acc;
  endfunction

  assign q_ready  = (q_op.mode != MODE_END) || !ovalid_r || out_tready;
  assign take     = q_valid && q_ready;
  assign do_write = take && (q_op.mode == MODE_APPEND) && (len_r < LW'(PATTERN_LEN));
  assign cur      = started_r ? active_r : init_r;

  always_comb begin
    adv = '0;
    for (int p = 0; p < PATTERN_LEN; p++) begin
      if (cur[p] && (LW'(p) < len_r)) begin
        if (star_r[p]) begin
          adv[p] = 1'b1;
        end else if (!semi_r[p] && (quest_r[p] || (store_r[p] == q_op.ch))) begin
          adv[p+1] = 1'b1;
        end
      end
    end
  end

  assign accept_now = (len_r != '0) && (cur[len_r] || (|(cur[PATTERN_LEN-1:0] & semi_r)));

  always_comb begin
    len_nxt     = len_r;
    ovf_nxt     = ovf_r;
    star_nxt    = star_r;
    semi_nxt    = semi_r;
    quest_nxt   = quest_r;
    init_nxt    = init_r;
    active_nxt  = active_r;
    started_nxt = started_r;
    matched_nxt = matched_r;
    oovf_nxt    = oovf_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    if (take) begin
      unique case (q_op.mode)
        MODE_APPEND: begin
          if (do_write) begin
            star_nxt[len_r[IW-1:0]]  = q_op.is_star;
            semi_nxt[len_r[IW-1:0]]  = q_op.is_semi;
            quest_nxt[len_r[IW-1:0]] = q_op.is_quest;
            len_nxt                  = len_r + 1'b1;
            init_nxt = close_stars({semi_nxt, 1'b1}, star_nxt);
          end else begin
            ovf_nxt = 1'b1;
          end
          started_nxt = 1'b0;
        end
        MODE_CLEAR: begin
          len_nxt     = '0;
          ovf_nxt     = 1'b0;
          star_nxt    = '0;
          semi_nxt    = '0;
          quest_nxt   = '0;
          init_nxt    = NPOS'(1);
          started_nxt = 1'b0;
        end
        MODE_SUBJ: begin
          active_nxt  = close_stars(adv, star_r);
          started_nxt = 1'b1;
        end
        MODE_END: begin
          matched_nxt = accept_now;
          oovf_nxt    = ovf_r;
          ovalid_nxt  = 1'b1;
          started_nxt = 1'b0;
        end
        default: begin
          started_nxt = started_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      ovf_r     <= 1'b0;
      star_r    <= '0;
      semi_r    <= '0;
      quest_r   <= '0;
      init_r    <= NPOS'(1);
      active_r  <= '0;
      started_r <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      len_r     <= len_nxt;
      ovf_r     <= ovf_nxt;
      star_r    <= star_nxt;
      semi_r    <= semi_nxt;
      quest_r   <= quest_nxt;
      init_r    <= init_nxt;
      active_r  <= active_nxt;
      started_r <= started_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    matched_r <= matched_nxt;
    oovf_r    <= oovf_nxt;
    if (do_write) begin
      store_r[len_r[IW-1:0]] <= q_op.ch;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'b0, oovf_r, matched_r};

endmodule

`default_nettype wire

>>> hw/rtl/wildcard_glob_match.sv
// ----------------------------------------------------------------------------
// wildcard_glob_match
// Glob matcher with ';'-separated alternatives, '*' and '?' wildcards.
//
// Input beats carry a kind in in_tuser and a byte in in_tdata: append a
// pattern byte, clear the pattern, stream a subject byte, or end the
// subject. Only the end beat produces an output beat: out_tdata[0] says
// whether some alternative matched the whole subject, out_tdata[1] says
// pattern bytes were dropped since the last clear.
// Throughput is one beat per cycle of any kind unless a held result
// stalls an end beat; the active position set advances by a whole
// subject byte for each subject beat taken by the back end.
// An accepted end beat passes the front queue, then the output register.
// A two-entry queue separates the front from the matcher. When out_tready
// is low, the held result stalls the next end beat at the queue head;
// beats behind it wait in the queue until it fills.
// Reset (rst_n low, synchronous) empties the queue, drops any pending
// result and leaves an empty pattern with no overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_glob_match
  import wgm_pkg::*;
#(
  parameter int PATTERN_LEN = PATTERN_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,    // [7:0] ch
  input  wire logic [1:0] in_tuser,    // [1:0] mode
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

  logic q_valid;
  logic q_ready;
  op_t  q_op;

  wgm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_op      (q_op)
  );

  wgm_back #(
    .PATTERN_LEN (PATTERN_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_op       (q_op),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

>>> hw/rtl/wgm_checker.sv
// ----------------------------------------------------------------------------
// wgm_checker
// Port-level checks for the glob matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_checker
  import wgm_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [1:0] in_tuser,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  logic [2:0] pend_r, pend_nxt;
  logic       end_beat;
  logic       out_beat;

  assign end_beat = in_tvalid && in_tready && (in_tuser == MODE_END);
  assign out_beat = out_tvalid && out_tready;

  always_comb begin
    pend_nxt = pend_r;
    if (end_beat && !out_beat) begin
      pend_nxt = pend_r + 1'b1;
    end else if (out_beat && !end_beat) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:2] == 6'd0))
    else $error("output padding bits not zero");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pend_r != 3'd0))
    else $error("output beat without a pending end beat");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind wildcard_glob_match wgm_checker u_wgm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
